### sv/resd_pkg.sv
package resd_pkg;

   // widths fixed by the register and field definitions
   localparam int PeriodW = 16;
   localparam int TickW   = PeriodW + 1;
   localparam int CsrIdxW = 8;

   typedef logic [PeriodW-1:0]  period_type;
   typedef logic [TickW-1:0]    tick_type;
   typedef logic [CsrIdxW-1:0]  csr_index_type;
   typedef logic signed [1:0]   increment_type;
   typedef logic [1:0]          history_type;

   // register indexes
   localparam csr_index_type CSR_ENCODER_PERIOD = 8'd0;
   localparam csr_index_type CSR_SWITCH_PERIOD  = 8'd1;

   // two-sample history: previous level high, new level low
   localparam history_type HIST_FALL = 2'b10;
   localparam history_type HIST_LOW  = 2'b00;

   // step codes
   localparam increment_type INC_NONE = 2'sb00;
   localparam increment_type INC_CW   = 2'sb01;
   localparam increment_type INC_CCW  = 2'sb11;

endpackage

### sv/resd_if.sv
interface resd_req_if;
   import resd_pkg::*;
   logic valid;
   logic ready;
   logic a_level;
   logic b_level;
   logic switch_level;
   modport source (output valid, a_level, b_level, switch_level, input ready);
   modport sink   (input valid, a_level, b_level, switch_level, output ready);
endinterface

interface resd_rsp_if;
   import resd_pkg::*;
   logic          valid;
   logic          ready;
   increment_type increment;
   logic          switch_pressed;
   modport source (output valid, increment, switch_pressed, input ready);
   modport sink   (input valid, increment, switch_pressed, output ready);
endinterface

interface resd_csr_if;
   import resd_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   period_type    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/resd_prescale.sv
module resd_prescale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  resd_pkg::period_type period,
   output logic                 fire
);
   import resd_pkg::*;

   tick_type count_ff;
   tick_type count_in;
   tick_type count_inc;

   assign count_inc = count_ff + tick_type'(1);
   // a lowered period fires at once if the count already passed it
   assign fire      = advance && (count_inc > {1'b0, period});

   always_comb begin
      if (!advance) begin
         count_in = count_ff;
      end else if (fire) begin
         count_in = '0;
      end else begin
         count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### sv/resd_encoder.sv
module resd_encoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    sample,
   input  logic                    a_level,
   input  logic                    b_level,
   output resd_pkg::increment_type increment
);
   import resd_pkg::*;

   history_type   a_hist_ff, a_hist_in;
   history_type   b_hist_ff, b_hist_in;
   increment_type inc_ff, inc_in;

   always_comb begin
      a_hist_in = a_hist_ff;
      b_hist_in = b_hist_ff;
      inc_in    = inc_ff;
      if (sample) begin
         a_hist_in = {a_hist_ff[0], a_level};
         b_hist_in = {b_hist_ff[0], b_level};
         if (a_hist_in == HIST_FALL && b_hist_in == HIST_LOW) begin
            inc_in = INC_CW;
         end else if (b_hist_in == HIST_FALL && a_hist_in == HIST_LOW) begin
            inc_in = INC_CCW;
         end else begin
            inc_in = INC_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_hist_ff <= '0;
         b_hist_ff <= '0;
         inc_ff    <= INC_NONE;
      end else begin
         a_hist_ff <= a_hist_in;
         b_hist_ff <= b_hist_in;
         inc_ff    <= inc_in;
      end
   end

   assign increment = inc_ff;

endmodule

### sv/resd_switch.sv
module resd_switch #(
   parameter int INTEGRATE_LIMIT = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic sample,
   input  logic switch_level,
   output logic switch_pressed
);
   import resd_pkg::*;

   localparam int IntW = $clog2(INTEGRATE_LIMIT + 1) + 1;
   localparam logic signed [IntW-1:0] LimHigh = IntW'(INTEGRATE_LIMIT);
   localparam logic signed [IntW-1:0] LimLow  = -LimHigh;

   logic signed [IntW-1:0] integ_ff, integ_in;
   logic                   pressed_ff, pressed_in;

   always_comb begin
      integ_in   = integ_ff;
      pressed_in = pressed_ff;
      if (sample) begin
         if (switch_level) begin
            if (integ_ff >= LimHigh) begin
               integ_in   = LimHigh;
               pressed_in = 1'b0;
            end else begin
               integ_in = integ_ff + IntW'(1);
            end
         end else begin
            if (integ_ff <= LimLow) begin
               integ_in   = LimLow;
               pressed_in = 1'b1;
            end else begin
               integ_in = integ_ff - IntW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff   <= '0;
         pressed_ff <= 1'b0;
      end else begin
         integ_ff   <= integ_in;
         pressed_ff <= pressed_in;
      end
   end

   assign switch_pressed = pressed_ff;

   a_integ_bounded: assert property (@(posedge clock) disable iff (reset)
      integ_ff >= LimLow && integ_ff <= LimHigh)
      else $error("switch integrator out of range");

endmodule

### sv/rotary_encoder_switch_debouncer_core.sv
// rotary encoder decoder with push-switch debounce
//
// req_if carries one sampling tick per request: levels of encoder channels a and b
// and of the switch pin. every accepted request gives exactly one response on
// rsp_if: the held step (+1, -1 or 0) and the debounced pressed flag, both as
// they stand after that tick.
// csr_if writes the two prescale periods (index 0 encoder, 1 switch, period is
// ticks between samples minus one); other indexes are ignored. it is always
// ready and is meant to be written while no request is in flight.
// a response is registered and is valid the cycle after its request is accepted.
// throughput: one request per cycle while rsp_if.ready stays high, set by the
// single state update per tick; the path state itself is the response register.
// when the receiver stalls, the response holds and req_if.ready follows
// rsp_if.ready, so one request can still be taken in the cycle the pending
// response leaves.
// reset (synchronous): periods 0, counters and histories 0, step 0, integrator
// 0, switch released, no response pending.
module rotary_encoder_switch_debouncer_core #(
   parameter int INTEGRATE_LIMIT = 10
) (
   input logic       clock,
   input logic       reset,
   resd_req_if.sink  req_if,
   resd_rsp_if.source rsp_if,
   resd_csr_if.sink  csr_if
);
   import resd_pkg::*;

   period_type enc_period_ff;
   period_type sw_period_ff;
   logic       rsp_valid_ff;
   logic       accept;
   logic       enc_fire;
   logic       sw_fire;

   // configuration writes, always taken
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_period_ff <= '0;
         sw_period_ff  <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_ENCODER_PERIOD: enc_period_ff <= csr_if.data;
            CSR_SWITCH_PERIOD:  sw_period_ff  <= csr_if.data;
            default: ;
         endcase
      end
   end

   // take a request whenever the response slot is empty or being drained
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // per-path prescalers, stepped once per tick
   resd_prescale u_enc_prescale (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .period  (enc_period_ff),
      .fire    (enc_fire)
   );

   resd_prescale u_sw_prescale (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .period  (sw_period_ff),
      .fire    (sw_fire)
   );

   // encoder step decode, output is the held step register
   resd_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .sample    (enc_fire),
      .a_level   (req_if.a_level),
      .b_level   (req_if.b_level),
      .increment (rsp_if.increment)
   );

   // switch integrator, output is the pressed flag register
   resd_switch #(
      .INTEGRATE_LIMIT (INTEGRATE_LIMIT)
   ) u_switch (
      .clock          (clock),
      .reset          (reset),
      .sample         (sw_fire),
      .switch_level   (req_if.switch_level),
      .switch_pressed (rsp_if.switch_pressed)
   );

   assign rsp_if.valid = rsp_valid_ff;

   // the held step is never the unused code
   a_inc_code: assert property (@(posedge clock) disable iff (reset)
      rsp_if.increment == INC_NONE || rsp_if.increment == INC_CW ||
      rsp_if.increment == INC_CCW)
      else $error("illegal step code");

   // an accepted request always leaves a response pending
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request without response");

   // a pending response is never overwritten before it is taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("response overwritten");

   // path state only moves on an accepted request
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(rsp_if.increment) && $stable(rsp_if.switch_pressed))
      else $error("state changed without a request");

endmodule

### bench/rotary_encoder_switch_debouncer_core_tb.sv
module rotary_encoder_switch_debouncer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import resd_pkg::*;

   // integrator limit, same as the default of the block
   localparam int LIMIT = 10;
   // index past the last register, the block must ignore it
   localparam csr_index_type CSR_SPARE  = 8'd2;
   localparam period_type    PERIOD_MAX = 16'hffff;

   // one sampling tick and one decoded outcome
   typedef struct packed {
      logic a;
      logic b;
      logic sw;
   } sample_type;

   typedef struct packed {
      increment_type step;
      logic          pressed;
   } outcome_type;

   logic clock;
   logic reset;

   resd_req_if req_if ();
   resd_rsp_if rsp_if ();
   resd_csr_if csr_if ();

   rotary_encoder_switch_debouncer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // decoder state as the bench sees it
   period_type    enc_prd;
   period_type    sw_prd;
   tick_type      enc_cnt;
   tick_type      sw_cnt;
   history_type   a_hist;
   history_type   b_hist;
   increment_type step_q;
   int            integ;
   logic          pressed_q;

   // outcomes owed by the block, oldest first
   outcome_type due_outputs[$];

   int   mismatches;
   int   ticks_sent;
   int   cw_seen;
   int   ccw_seen;
   int   press_changes;
   logic last_pressed;

   // calm: no idling on either side; stall_ask: one long hold-off of the receiver
   bit calm;
   bit stall_ask;
   int stall_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // generous ceiling on the whole run
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // one tick through both paths, state advanced in place
   function automatic outcome_type decode_tick(sample_type t);
      outcome_type o;
      // encoder prescaler: count first, then compare with the current period
      enc_cnt = enc_cnt + 1'b1;
      if (enc_cnt > tick_type'(enc_prd)) begin
         enc_cnt = '0;
         a_hist  = {a_hist[0], t.a};
         b_hist  = {b_hist[0], t.b};
         // a falls while b stays low is clockwise, the mirror is counter-clockwise
         if (a_hist == HIST_FALL && b_hist == HIST_LOW) begin
            step_q = INC_CW;
         end else if (b_hist == HIST_FALL && a_hist == HIST_LOW) begin
            step_q = INC_CCW;
         end else begin
            step_q = INC_NONE;
         end
      end
      // switch prescaler and saturating integrator
      sw_cnt = sw_cnt + 1'b1;
      if (sw_cnt > tick_type'(sw_prd)) begin
         sw_cnt = '0;
         if (t.sw) begin
            // pushing past the top limit means released
            if (integ >= LIMIT) begin
               integ     = LIMIT;
               pressed_q = 1'b0;
            end else begin
               integ++;
            end
         end else begin
            // pushing past the bottom limit means pressed
            if (integ <= -LIMIT) begin
               integ     = -LIMIT;
               pressed_q = 1'b1;
            end else begin
               integ--;
            end
         end
      end
      o.step    = step_q;
      o.pressed = pressed_q;
      return o;
   endfunction

   // scoreboard: check responses, follow register writes, predict each request
   always @(posedge clock) begin : scoreboard
      outcome_type want;
      sample_type  t;
      if (reset) begin
         enc_prd      = '0;
         sw_prd       = '0;
         enc_cnt      = '0;
         sw_cnt       = '0;
         a_hist       = '0;
         b_hist       = '0;
         step_q       = INC_NONE;
         integ        = 0;
         pressed_q    = 1'b0;
         last_pressed = 1'b0;
         due_outputs.delete();
      end else begin
         // a response at this edge belongs to a request from an earlier edge
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_outputs.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = due_outputs.pop_front();
               if (rsp_if.increment !== want.step) begin
                  $error("increment: expected %0d, got %0d", want.step, rsp_if.increment);
                  mismatches++;
               end
               if (rsp_if.switch_pressed !== want.pressed) begin
                  $error("switch_pressed: expected %0d, got %0d",
                         want.pressed, rsp_if.switch_pressed);
                  mismatches++;
               end
               if (want.step == INC_CW) cw_seen++;
               if (want.step == INC_CCW) ccw_seen++;
               if (want.pressed != last_pressed) press_changes++;
               last_pressed = want.pressed;
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_ENCODER_PERIOD: enc_prd = csr_if.data;
               CSR_SWITCH_PERIOD:  sw_prd  = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            t.a  = req_if.a_level;
            t.b  = req_if.b_level;
            t.sw = req_if.switch_level;
            due_outputs.push_back(decode_tick(t));
         end
      end
   end

   // receiver: random back-pressure, or one long hold-off counted here
   always begin
      @(posedge clock);
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if (stall_ask) begin
         stall_ask  = 1'b0;
         stall_left = 60;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(99) >= 28);
      end
   end

   // offer one tick, with random gaps ahead of it, and wait for the handshake
   task automatic send_tick(sample_type t);
      if (!calm) begin
         while ($urandom_range(99) < 28) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid        <= 1'b1;
      req_if.a_level      <= t.a;
      req_if.b_level      <= t.b;
      req_if.switch_level <= t.sw;
      do @(posedge clock); while (!req_if.ready);
      ticks_sent++;
   endtask

   // stop offering and let every owed response come back
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (due_outputs.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // register write; drops valid again before returning, so writes can be called one after another
   task automatic write_reg(csr_index_type idx, period_type val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // both directions, a double fall and noise, with the switch held low
   // long enough to saturate and read pressed
   task automatic test_step_directions();
      sample_type walk [12];
      walk = '{3'b100, 3'b000, 3'b000, 3'b010, 3'b000, 3'b110,
               3'b000, 3'b100, 3'b110, 3'b010, 3'b000, 3'b000};
      foreach (walk[i]) send_tick(walk[i]);
      settle();
   endtask

   // counters run up under the largest periods, then the periods drop below
   // the count so both paths fire at once and restart
   task automatic test_period_change();
      write_reg(CSR_ENCODER_PERIOD, PERIOD_MAX);
      write_reg(CSR_SWITCH_PERIOD, PERIOD_MAX);
      write_reg(CSR_SPARE, 16'h0005);
      for (int i = 0; i < 5; i++) send_tick(sample_type'(3'($urandom_range(7))));
      settle();
      write_reg(CSR_ENCODER_PERIOD, 16'd3);
      write_reg(CSR_SWITCH_PERIOD, 16'd2);
      send_tick(3'b101);
      send_tick(3'b001);
      send_tick(3'b011);
      settle();
   endtask

   // quadrature walk with random hold times and a little noise, switch runs
   // with occasional bounce
   task automatic run_burst(period_type enc_p, period_type sw_p, int n,
                            bit no_idle, bit with_stall);
      logic [1:0] pos;
      logic [1:0] ab;
      int         enc_hold;
      int         sw_hold;
      logic       sw_lvl;
      sample_type t;
      pos      = '0;
      ab       = '0;
      enc_hold = 0;
      sw_hold  = 0;
      sw_lvl   = 1'($urandom_range(1));
      write_reg(CSR_ENCODER_PERIOD, enc_p);
      write_reg(CSR_SWITCH_PERIOD, sw_p);
      calm = no_idle;
      for (int i = 0; i < n; i++) begin
         if (with_stall && i == n / 3) stall_ask = 1'b1;
         if (enc_hold == 0) begin
            if ($urandom_range(9) == 0) begin
               // glitch: any level pair
               ab = 2'($urandom_range(3));
            end else begin
               // one gray-code step either way
               pos = pos + ($urandom_range(1) ? 2'd1 : 2'd3);
               ab  = {pos[0] ^ pos[1], pos[1]};
            end
            enc_hold = $urandom_range(1, 2 * (int'(enc_p) + 1));
         end
         enc_hold--;
         if (sw_hold == 0) begin
            sw_lvl  = ~sw_lvl;
            sw_hold = $urandom_range(4, 30) * (int'(sw_p) + 1);
         end
         sw_hold--;
         t.a  = ab[1];
         t.b  = ab[0];
         t.sw = sw_lvl ^ ($urandom_range(19) == 0);
         send_tick(t);
      end
      settle();
      calm = 1'b0;
   endtask

   initial begin
      mismatches    = 0;
      ticks_sent    = 0;
      cw_seen       = 0;
      ccw_seen      = 0;
      press_changes = 0;
      calm          = 1'b0;
      stall_ask     = 1'b0;
      stall_left    = 0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.a_level      <= 1'b0;
      req_if.b_level      <= 1'b0;
      req_if.switch_level <= 1'b0;
      rsp_if.ready        <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= CSR_ENCODER_PERIOD;
      csr_if.data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset periods first
      test_step_directions();
      test_period_change();

      // random part over several period settings, extremes included
      run_burst(16'd0, 16'd0, 350, 1'b0, 1'b1);
      run_burst(16'd1, 16'd3, 300, 1'b0, 1'b0);
      run_burst(16'd3, 16'd0, 300, 1'b1, 1'b0);
      run_burst(PERIOD_MAX, 16'd0, 150, 1'b0, 1'b0);
      run_burst(16'd0, PERIOD_MAX, 150, 1'b0, 1'b1);
      run_burst(period_type'($urandom_range(7)), period_type'($urandom_range(7)),
                300, 1'b0, 1'b0);

      // drain every owed response, then let the block run idle
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (due_outputs.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("sent %0d ticks over eight period settings incl. 0 and 65535",
               ticks_sent);
      $display("saw %0d cw and %0d ccw steps, %0d switch state changes",
               cw_seen, ccw_seen, press_changes);
      if (mismatches == 0 && due_outputs.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
sv/resd_pkg.sv
sv/resd_if.sv
sv/resd_prescale.sv
sv/resd_encoder.sv
sv/resd_switch.sv
sv/rotary_encoder_switch_debouncer_core.sv
bench/rotary_encoder_switch_debouncer_core_tb.sv
